>>> hw/rtl/cluster_chain_table_engine_core_assert.svh
// Assertion macros for the cluster chain table engine checker.
`ifndef CLUSTER_CHAIN_TABLE_ENGINE_CORE_ASSERT_SVH
`define CLUSTER_CHAIN_TABLE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define CCTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define CCTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ccte_pkg.sv
// Types and constants shared by the cluster chain table engine files.
package ccte_pkg;

  localparam logic [15:0] END_MARK    = 16'hFFFF;
  localparam logic [15:0] FREE_MARK   = 16'h0000;
  localparam int unsigned ALLOC_END   = 2304;
  localparam logic [15:0] LIMIT_RESET = 16'd2880;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_ALLOC  = 3'd1,
    OP_EXTEND = 3'd2,
    OP_FREE   = 3'd3,
    OP_CHECK  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_NOFREE  = 3'd1,
    STAT_DIFFER  = 3'd2,
    STAT_TOOLONG = 3'd3,
    STAT_RANGE   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WCHK,
    S_WRD,
    S_SCAN,
    S_TAKE,
    S_LINK,
    S_DONE
  } state_e;

endpackage

>>> hw/rtl/ccte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccte_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/cluster_chain_table_engine_core.sv
// Cluster chain table engine: two mirrored link tables under one sequencer.
//
//  Channel | Direction | Handshake              | Beat carries
//  --------+-----------+------------------------+-----------------------------------------
//  in      | to block  | in_valid_i/in_ready_o  | opcode, cluster_index, copy_select, value
//  out     | from block| out_valid_o/out_ready_i| status, result_cluster, chain_length
//  cfg     | to block  | cfg_valid_i/cfg_ready_o| max_chain_length
//
//  After reset both tables are swept to zero, one entry per cycle, with in_ready_o low
//  (cfg writes are taken throughout).
//  Allocate scans the primary table through its single read port, one entry per cycle.
//  Extend, free and check walk each link as a read issue followed by its data return;
//  extend adds the allocate scan.
//  One request in flight; the next is taken while the previous result waits in the
//  output register. A stalled output only holds the sequencer at its final step.
module cluster_chain_table_engine_core
  import ccte_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned FIRST_USABLE  = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] cluster_index_i,
  input  logic        copy_select_i,
  input  logic [15:0] entry_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] result_cluster_o,
  output logic [15:0] chain_length_o,
  // config channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_max_chain_length_i
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned WIN_END_INT =
      (ALLOC_END < TABLE_ENTRIES) ? ALLOC_END : TABLE_ENTRIES;
  localparam logic [16:0]   TE_EXT   = 17'(TABLE_ENTRIES);
  localparam logic [AW:0]   WIN_END  = (AW+1)'(WIN_END_INT);
  localparam logic [AW:0]   WIN_FROM = (AW+1)'(FIRST_USABLE);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  // ---------------------------------------------------------------- state
  state_e        state_q, state_d;
  op_e           op_q, op_d;
  status_e       st_q, st_d;
  logic [15:0]   cur_q, cur_d;    // walk position
  logic [15:0]   cnt_q, cnt_d;    // links walked
  logic [15:0]   clu_q, clu_d;    // cluster found by the scan
  logic [AW:0]   sa_q, sa_d;      // scan issue address
  logic [AW-1:0] pa_q, pa_d;      // address whose data returns this cycle
  logic          pv_q, pv_d;      // pa_q valid
  logic [AW-1:0] clr_q, clr_d;    // clearing sweep address
  logic [15:0]   max_q;

  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_st_q;
  logic [15:0]   out_clu_q, out_len_q;
  logic          out_load;

  // ---------------------------------------------------------------- table ports
  logic          p_we, m_we;
  logic [AW-1:0] p_waddr, m_waddr, raddr;
  logic [15:0]   p_wdata, m_wdata, p_rdata, m_rdata;

  ccte_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_primary (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (raddr),
    .rdata_o (p_rdata)
  );

  ccte_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_mirror (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (raddr),
    .rdata_o (m_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    st_d     = st_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    clu_d    = clu_q;
    sa_d     = sa_q;
    pa_d     = pa_q;
    pv_d     = pv_q;
    clr_d    = clr_q;
    out_load = 1'b0;

    p_we     = 1'b0;
    m_we     = 1'b0;
    p_waddr  = cur_q[AW-1:0];
    m_waddr  = cur_q[AW-1:0];
    p_wdata  = FREE_MARK;
    m_wdata  = FREE_MARK;
    raddr    = cur_q[AW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        p_we    = 1'b1;
        m_we    = 1'b1;
        p_waddr = clr_q;
        m_waddr = clr_q;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = op_e'(opcode_i);
          st_d  = STAT_OK;
          cur_d = cluster_index_i;
          cnt_d = '0;
          clu_d = '0;
          sa_d  = WIN_FROM;
          pv_d  = 1'b0;
          unique case (opcode_i)
            OP_LOAD: begin
              state_d = S_DONE;
              if ({1'b0, cluster_index_i} >= TE_EXT) begin
                st_d = STAT_RANGE;
              end else begin
                p_we    = !copy_select_i;
                m_we    = copy_select_i;
                p_waddr = cluster_index_i[AW-1:0];
                m_waddr = cluster_index_i[AW-1:0];
                p_wdata = entry_value_i;
                m_wdata = entry_value_i;
              end
            end
            OP_ALLOC: state_d = S_SCAN;
            OP_EXTEND: begin
              if (cluster_index_i == END_MARK) begin
                st_d    = STAT_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_WCHK;
              end
            end
            OP_FREE, OP_CHECK: state_d = S_WCHK;
            default: state_d = S_DONE;
          endcase
        end
      end

      S_WCHK: begin
        // stop tests ahead of each link; otherwise issue the read
        if (cur_q == END_MARK) begin
          state_d = S_DONE;
        end else if ({1'b0, cur_q} >= TE_EXT) begin
          st_d    = STAT_RANGE;
          state_d = S_DONE;
        end else if (cnt_q >= max_q) begin
          st_d    = STAT_TOOLONG;
          state_d = S_DONE;
        end else begin
          state_d = S_WRD;
        end
      end

      S_WRD: begin
        state_d = S_WCHK;
        case (op_q)
          OP_EXTEND: begin
            if (p_rdata == END_MARK) begin
              state_d = S_SCAN;    // tail found, cur_q kept as the tail
            end else begin
              cnt_d = cnt_q + 16'd1;
              cur_d = p_rdata;
            end
          end
          OP_FREE: begin
            p_we  = 1'b1;
            m_we  = 1'b1;
            cnt_d = cnt_q + 16'd1;
            cur_d = p_rdata;
          end
          default: begin
            if (p_rdata != m_rdata) begin
              st_d    = STAT_DIFFER;
              state_d = S_DONE;
            end else begin
              cnt_d = cnt_q + 16'd1;
              cur_d = p_rdata;
            end
          end
        endcase
      end

      S_SCAN: begin
        raddr = sa_q[AW-1:0];
        if (pv_q && (p_rdata == FREE_MARK)) begin
          clu_d   = 16'(pa_q);
          state_d = S_TAKE;
        end else if (sa_q < WIN_END) begin
          pa_d = sa_q[AW-1:0];
          pv_d = 1'b1;
          sa_d = sa_q + (AW+1)'(1);
        end else begin
          st_d    = STAT_NOFREE;
          state_d = S_DONE;
        end
      end

      S_TAKE: begin
        p_we    = 1'b1;
        m_we    = 1'b1;
        p_waddr = clu_q[AW-1:0];
        m_waddr = clu_q[AW-1:0];
        p_wdata = END_MARK;
        m_wdata = END_MARK;
        state_d = (op_q == OP_EXTEND) ? S_LINK : S_DONE;
      end

      S_LINK: begin
        p_we    = 1'b1;
        m_we    = 1'b1;
        p_wdata = clu_q;
        m_wdata = clu_q;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      max_q       <= LIMIT_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        max_q <= cfg_max_chain_length_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    st_q  <= st_d;
    cur_q <= cur_d;
    cnt_q <= cnt_d;
    clu_q <= clu_d;
    sa_q  <= sa_d;
    pa_q  <= pa_d;
    if (out_load) begin
      out_st_q  <= st_q;
      out_clu_q <= clu_q;
      out_len_q <= (op_q == OP_EXTEND) ? 16'd0 : cnt_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign result_cluster_o = out_clu_q;
  assign chain_length_o   = out_len_q;

endmodule

>>> hw/rtl/ccte_chk.sv
// Port-level checker for the cluster chain table engine, bound to the top level.
`include "cluster_chain_table_engine_core_assert.svh"

module ccte_chk
  import ccte_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [15:0] result_cluster_o,
  input logic [15:0] chain_length_o
);

  // a held result beat keeps its status and result cluster
  `CCTE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(status_o) && $stable(result_cluster_o), "result beat changed")

  // one request at a time: no second beat right after one is taken
  `CCTE_ASSERT_NEXT(a_one_busy, in_valid_i && in_ready_o, !in_ready_o,
    "request taken while busy")

  // an allocated cluster only comes with success and no walk count
  `CCTE_ASSERT_NOW(a_alloc_ok, out_valid_o && (result_cluster_o != 16'd0),
    (status_o == STAT_OK) && (chain_length_o == 16'd0), "cluster with bad status")

  // allocation failure reports nothing else
  `CCTE_ASSERT_NOW(a_nofree, out_valid_o && (status_o == STAT_NOFREE),
    (result_cluster_o == 16'd0) && (chain_length_o == 16'd0), "no-free result not clean")

endmodule

bind cluster_chain_table_engine_core ccte_chk u_ccte_chk (.*);

>>> dv/cluster_chain_table_engine_core_tb.sv
// Self-checking testbench for the cluster chain table engine: directed table, then random.
module cluster_chain_table_engine_core_tb
  import ccte_pkg::*;
();

  // Block geometry, kept at the defaults of the top level.
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned FIRST_USABLE  = 2;
  // Allocation window: FIRST_USABLE up to the smaller of ALLOC_END and the table size.
  localparam int unsigned SCAN_END = (ALLOC_END < TABLE_ENTRIES) ? ALLOC_END : TABLE_ENTRIES;

  // Opcode with no operation behind it; expected to be a no-op.
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Random traffic keeps walks and allocate scans short so the run stays cheap.
  localparam int unsigned WALK_BUDGET  = 200;
  localparam int          ALLOC_BUDGET = 400;
  localparam int unsigned PHASE_ITEMS  = 360;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] idx;
    logic        sel;
    logic [15:0] val;
  } chain_request_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] cluster;
    logic [15:0] length;
  } chain_outcome_t;

  typedef enum logic {
    ROW_REQUEST,
    ROW_CONFIG
  } row_kind_e;

  // One directed step: a request (optionally with its result typed in) or a limit write,
  // the new limit riding in the val field.
  typedef struct packed {
    row_kind_e      kind;
    chain_request_t req;
    logic           given_valid;
    chain_outcome_t given;
  } directed_row_t;

  localparam chain_outcome_t NO_GIVEN  = '{STAT_OK, 16'd0, 16'd0};
  localparam chain_outcome_t GIVEN_OK  = '{STAT_OK, 16'd0, 16'd0};
  localparam chain_outcome_t GIVEN_RNG = '{STAT_RANGE, 16'd0, 16'd0};
  localparam int unsigned    DIRECTED_ROWS = 29;

  // DUT-facing signals, all known from time zero.
  logic        clk_i;
  logic        rst_ni                 = 1'b0;
  logic        in_valid_i             = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i               = '0;
  logic [15:0] cluster_index_i        = '0;
  logic        copy_select_i          = 1'b0;
  logic [15:0] entry_value_i          = '0;
  logic        out_valid_o;
  logic        out_ready_i            = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] result_cluster_o;
  logic [15:0] chain_length_o;
  logic        cfg_valid_i            = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_max_chain_length_i = '0;

  // Shadow copy of the block: both link tables and the walk limit.
  logic [15:0]    primary_links [TABLE_ENTRIES];
  logic [15:0]    mirror_links  [TABLE_ENTRIES];
  logic [15:0]    chain_limit;

  chain_outcome_t pending_outcomes [$];
  logic [15:0]    chain_heads [$];
  directed_row_t  directed_rows [DIRECTED_ROWS];
  chain_outcome_t oldest;

  int unsigned sender_gap_pct     = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned requests_sent      = 0;
  int unsigned results_checked    = 0;
  int unsigned error_count        = 0;
  int unsigned cycle_count        = 0;
  int unsigned status_tally [8];

  cluster_chain_table_engine_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FIRST_USABLE (FIRST_USABLE)
  ) u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .opcode_i              (opcode_i),
    .cluster_index_i       (cluster_index_i),
    .copy_select_i         (copy_select_i),
    .entry_value_i         (entry_value_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .status_o              (status_o),
    .result_cluster_o      (result_cluster_o),
    .chain_length_o        (chain_length_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_max_chain_length_i(cfg_max_chain_length_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // First free cluster in the allocation window, -1 when the window is full.
  function automatic int first_free_slot();
    for (int i = FIRST_USABLE; i < SCAN_END; i++) begin
      if (primary_links[i] == FREE_MARK) return i;
    end
    return -1;
  endfunction

  // Links a walk would visit, without touching the tables; stops just past the budget.
  // Any revisit means a loop, which runs on to the limit, so freeing cannot shorten a
  // walk that this finds within budget.
  function automatic int unsigned walk_steps(input logic [15:0] start, input bit to_tail);
    logic [15:0] cur;
    int unsigned steps;
    cur   = start;
    steps = 0;
    while (cur != END_MARK && cur < TABLE_ENTRIES && steps < chain_limit &&
           steps <= WALK_BUDGET) begin
      if (to_tail && primary_links[cur] == END_MARK) break;
      steps++;
      cur = primary_links[cur];
    end
    return steps;
  endfunction

  // Applies one request to the shadow tables and returns the result the block owes.
  function automatic chain_outcome_t predict_request(input chain_request_t rq);
    chain_outcome_t res;
    logic [15:0]    cur;
    logic [15:0]    nxt;
    int unsigned    count;
    int             slot_at;
    bit             done;
    res = '{STAT_OK, 16'd0, 16'd0};
    case (rq.op)
      OP_LOAD: begin
        if (rq.idx >= TABLE_ENTRIES) res.status = STAT_RANGE;
        else if (!rq.sel) primary_links[rq.idx] = rq.val;
        else mirror_links[rq.idx] = rq.val;
      end
      OP_ALLOC: begin
        slot_at = first_free_slot();
        if (slot_at < 0) begin
          res.status = STAT_NOFREE;
        end else begin
          primary_links[slot_at] = END_MARK;
          mirror_links[slot_at]  = END_MARK;
          res.cluster            = 16'(slot_at);
        end
      end
      OP_EXTEND, OP_FREE, OP_CHECK: begin
        cur   = rq.idx;
        count = 0;
        done  = 1'b0;
        // an end marker has no tail to extend after
        if (rq.op == OP_EXTEND && cur == END_MARK) begin
          res.status = STAT_RANGE;
          done       = 1'b1;
        end
        while (!done) begin
          if (cur == END_MARK) begin
            done = 1'b1;
          end else if (cur >= TABLE_ENTRIES) begin
            res.status = STAT_RANGE;
            done       = 1'b1;
          end else if (count >= chain_limit) begin
            res.status = STAT_TOOLONG;
            done       = 1'b1;
          end else begin
            nxt = primary_links[cur];
            if (rq.op == OP_EXTEND) begin
              if (nxt == END_MARK) begin
                slot_at = first_free_slot();
                if (slot_at < 0) begin
                  res.status = STAT_NOFREE;
                end else begin
                  primary_links[cur]     = 16'(slot_at);
                  mirror_links[cur]      = 16'(slot_at);
                  primary_links[slot_at] = END_MARK;
                  mirror_links[slot_at]  = END_MARK;
                  res.cluster            = 16'(slot_at);
                end
                done = 1'b1;
              end
            end else if (rq.op == OP_FREE) begin
              primary_links[cur] = FREE_MARK;
              mirror_links[cur]  = FREE_MARK;
            end else if (primary_links[cur] != mirror_links[cur]) begin
              res.status = STAT_DIFFER;
              done       = 1'b1;
            end
            if (!done) begin
              count++;
              cur = nxt;
            end
          end
        end
        if (rq.op != OP_EXTEND) res.length = count[15:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Queues the expected result (typed-in one if given), then offers the beat after a
  // random gap and holds it until the block takes it. Returns at the accepting edge.
  task automatic issue_request(input chain_request_t rq, input bit given_valid,
                               input chain_outcome_t given, output chain_outcome_t got);
    got = predict_request(rq);
    pending_outcomes.push_back(given_valid ? given : got);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= rq.op;
    cluster_index_i <= rq.idx;
    copy_select_i   <= rq.sel;
    entry_value_i   <= rq.val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Drops valid, then waits on the clock until every outstanding result is checked.
  task automatic settle_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
  endtask

  // Only called with the block idle.
  task automatic write_chain_limit(input logic [15:0] limit);
    cfg_valid_i            <= 1'b1;
    cfg_max_chain_length_i <= limit;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    chain_limit = limit;
  endtask

  // Mostly well-formed chain traffic on tracked heads, with tampering and noise mixed in.
  task automatic run_random_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                                  input logic [15:0] limit, input int unsigned items);
    chain_request_t rq;
    chain_outcome_t got;
    int             pick;
    int             slot;
    int             free_at;
    settle_results();
    write_chain_limit(limit);
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      // unused fields vary too
      rq   = '{OP_ALLOC, 16'($urandom), 1'($urandom), 16'($urandom)};
      if (pick >= 18 && pick < 70 && chain_heads.size() == 0) pick = 0;
      if (pick < 18 && chain_heads.size() >= 24) begin
        // too many live chains: release the oldest instead
        rq.op  = OP_FREE;
        rq.idx = chain_heads.pop_front();
      end else if (pick < 18) begin
        rq.op = OP_ALLOC;
      end else if (pick < 36) begin
        rq.op  = OP_EXTEND;
        rq.idx = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
      end else if (pick < 50) begin
        rq.op  = OP_CHECK;
        rq.idx = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
      end else if (pick < 60) begin
        slot   = $urandom_range(0, chain_heads.size() - 1);
        rq.op  = OP_FREE;
        rq.idx = chain_heads[slot];
        chain_heads.delete(slot);
      end else if (pick < 64) begin
        // spoil or repair the mirror of a head entry
        rq.op  = OP_LOAD;
        rq.idx = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
        rq.sel = 1'b1;
        if ($urandom_range(0, 1) == 0) rq.val = primary_links[rq.idx];
      end else if (pick < 70) begin
        // relink a head: cut it short, splice another chain on, or point anywhere
        rq.op  = OP_LOAD;
        rq.idx = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
        rq.sel = 1'b0;
        case ($urandom_range(0, 2))
          0:       rq.val = END_MARK;
          1:       rq.val = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
          default: rq.val = 16'($urandom_range(0, TABLE_ENTRIES - 1));
        endcase
      end else if (pick < 78) begin
        case ($urandom_range(0, 2))
          0:       rq.op = OP_EXTEND;
          1:       rq.op = OP_FREE;
          default: rq.op = OP_CHECK;
        endcase
        case ($urandom_range(0, 2))
          0:       rq.idx = 16'($urandom_range(0, TABLE_ENTRIES - 1));
          1:       rq.idx = END_MARK;
          default: ;
        endcase
      end else if (pick < 88) begin
        rq.op = OP_LOAD;
      end else begin
        rq.op = 3'($urandom);
      end

      // Long walks (loops mostly) are cut at their start; a crowded window gets a hole
      // punched low down so the allocate scan stays short.
      if (rq.op inside {OP_EXTEND, OP_FREE, OP_CHECK} &&
          walk_steps(rq.idx, rq.op == OP_EXTEND) > WALK_BUDGET) begin
        rq.op  = OP_LOAD;
        rq.sel = 1'b0;
        rq.val = END_MARK;
      end else if (rq.op == OP_ALLOC || rq.op == OP_EXTEND) begin
        free_at = first_free_slot();
        if (free_at < 0 || free_at > ALLOC_BUDGET) begin
          rq.op  = OP_LOAD;
          rq.idx = 16'($urandom_range(FIRST_USABLE, ALLOC_BUDGET));
          rq.sel = 1'b0;
          rq.val = FREE_MARK;
        end
      end

      // now and then the sender holds off until the block has drained
      if ($urandom_range(0, 49) == 0) settle_results();
      issue_request(rq, 1'b0, NO_GIVEN, got);
      if (rq.op == OP_ALLOC && got.status == STAT_OK) chain_heads.push_back(got.cluster);
    end
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Result checker: every accepted beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      status_tally[status_o]++;
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing expected: status %0d cluster %0d length %0d",
               status_o, result_cluster_o, chain_length_o);
        error_count++;
      end else begin
        oldest = pending_outcomes.pop_front();
        results_checked++;
        if (status_o !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, status_o);
          error_count++;
        end
        if (result_cluster_o !== oldest.cluster) begin
          $error("result_cluster: expected %0d, got %0d", oldest.cluster, result_cluster_o);
          error_count++;
        end
        if (chain_length_o !== oldest.length) begin
          $error("chain_length: expected %0d, got %0d", oldest.length, chain_length_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    chain_outcome_t got;

    foreach (primary_links[i]) begin
      primary_links[i] = FREE_MARK;
      mirror_links[i]  = FREE_MARK;
    end
    foreach (status_tally[i]) status_tally[i] = 0;
    chain_limit = LIMIT_RESET;

    // Directed table. Typed results only where obvious: after reset, bounds, empty chains,
    // plain loads, the self-loop at the widest limit. Everything else goes to the predictor.
    directed_rows = '{
      // fresh tables: first free cluster is the first usable one
      '{ROW_REQUEST, '{OP_ALLOC,  16'd0,    1'b0, 16'd0},    1'b1, '{STAT_OK, 16'd2, 16'd0}},
      '{ROW_REQUEST, '{OP_ALLOC,  16'd0,    1'b1, 16'hFFFF}, 1'b0, NO_GIVEN},
      '{ROW_REQUEST, '{OP_EXTEND, 16'd2,    1'b0, 16'd0},    1'b0, NO_GIVEN},
      '{ROW_REQUEST, '{OP_CHECK,  16'd2,    1'b0, 16'd0},    1'b0, NO_GIVEN},
      // index extremes
      '{ROW_REQUEST, '{OP_LOAD,   16'd4095, 1'b1, 16'hFFFF}, 1'b1, GIVEN_OK},
      '{ROW_REQUEST, '{OP_LOAD,   16'd4096, 1'b0, 16'h1234}, 1'b1, GIVEN_RNG},
      '{ROW_REQUEST, '{OP_LOAD,   16'hFFFF, 1'b1, 16'h0000}, 1'b1, GIVEN_RNG},
      // end marker as start: no tail for extend, empty chain for free
      '{ROW_REQUEST, '{OP_EXTEND, 16'hFFFF, 1'b0, 16'd0},    1'b1, GIVEN_RNG},
      '{ROW_REQUEST, '{OP_FREE,   16'hFFFF, 1'b0, 16'd0},    1'b1, GIVEN_OK},
      '{ROW_REQUEST, '{OP_CHECK,  16'd4096, 1'b0, 16'd0},    1'b1, GIVEN_RNG},
      // spoil the mirror of the tail, then check and free the chain
      '{ROW_REQUEST, '{OP_LOAD,   16'd4,    1'b1, 16'h1234}, 1'b1, GIVEN_OK},
      '{ROW_REQUEST, '{OP_CHECK,  16'd2,    1'b0, 16'd0},    1'b0, NO_GIVEN},
      '{ROW_REQUEST, '{OP_FREE,   16'd2,    1'b0, 16'd0},    1'b0, NO_GIVEN},
      // free entries link to entry 0; make entry 0 an end in both copies first
      '{ROW_REQUEST, '{OP_LOAD,   16'd0,    1'b0, 16'hFFFF}, 1'b1, GIVEN_OK},
      '{ROW_REQUEST, '{OP_LOAD,   16'd0,    1'b1, 16'hFFFF}, 1'b1, GIVEN_OK},
      '{ROW_REQUEST, '{OP_CHECK,  16'd5,    1'b0, 16'd0},    1'b0, NO_GIVEN},
      // free stopping on an out-of-range link keeps what it already freed
      '{ROW_REQUEST, '{OP_LOAD,   16'd3,    1'b0, 16'd4097}, 1'b1, GIVEN_OK},
      '{ROW_REQUEST, '{OP_FREE,   16'd3,    1'b0, 16'd0},    1'b0, NO_GIVEN},
      '{ROW_REQUEST, '{OP_UNUSED_HI, 16'hFFFF, 1'b1, 16'hFFFF}, 1'b1, GIVEN_OK},
      // narrowest limit: one link, extend past it is too long
      '{ROW_CONFIG,  '{OP_LOAD,   16'd0,    1'b0, 16'd1},    1'b0, NO_GIVEN},
      '{ROW_REQUEST, '{OP_ALLOC,  16'd0,    1'b0, 16'd0},    1'b0, NO_GIVEN},
      '{ROW_REQUEST, '{OP_EXTEND, 16'd2,    1'b0, 16'd0},    1'b0, NO_GIVEN},
      '{ROW_REQUEST, '{OP_EXTEND, 16'd2,    1'b0, 16'd0},    1'b0, NO_GIVEN},
      // widest limit against a self-loop: the length saturates at the limit
      '{ROW_CONFIG,  '{OP_LOAD,   16'd0,    1'b0, 16'hFFFF}, 1'b0, NO_GIVEN},
      '{ROW_REQUEST, '{OP_LOAD,   16'd10,   1'b0, 16'd10},   1'b1, GIVEN_OK},
      '{ROW_REQUEST, '{OP_LOAD,   16'd10,   1'b1, 16'd10},   1'b1, GIVEN_OK},
      '{ROW_REQUEST, '{OP_CHECK,  16'd10,   1'b0, 16'd0},    1'b1,
        '{STAT_TOOLONG, 16'd0, 16'hFFFF}},
      '{ROW_REQUEST, '{OP_FREE,   16'd10,   1'b0, 16'd0},    1'b0, NO_GIVEN},
      '{ROW_CONFIG,  '{OP_LOAD,   16'd0,    1'b0, LIMIT_RESET}, 1'b0, NO_GIVEN}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CONFIG) begin
        settle_results();
        write_chain_limit(directed_rows[r].req.val);
      end else begin
        issue_request(directed_rows[r].req, directed_rows[r].given_valid,
                      directed_rows[r].given, got);
      end
    end

    // Random phases: idling pattern and walk limit per phase, extremes included.
    run_random_phase(0, 0, 16'd1, PHASE_ITEMS);
    run_random_phase(79, 0, 16'hFFFF, PHASE_ITEMS);
    run_random_phase(0, 79, 16'($urandom_range(2, 12)), PHASE_ITEMS);
    run_random_phase(10, 10, LIMIT_RESET, PHASE_ITEMS);
    run_random_phase(0, 0, 16'($urandom_range(13, 400)), PHASE_ITEMS);

    settle_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", pending_outcomes.size());
      error_count++;
    end

    $display("Covered: directed table, five random phases with limits 1..65535");
    $display("  %0d requests, %0d results; ok %0d no-free %0d differ %0d too-long %0d range %0d",
             requests_sent, results_checked, status_tally[STAT_OK], status_tally[STAT_NOFREE],
             status_tally[STAT_DIFFER], status_tally[STAT_TOOLONG], status_tally[STAT_RANGE]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ccte_pkg.sv
hw/rtl/ccte_ram.sv
hw/rtl/cluster_chain_table_engine_core.sv
hw/rtl/ccte_chk.sv
dv/cluster_chain_table_engine_core_tb.sv
